@@ hw/rtl/vcmv_pkg.sv @@
// shared types, constants and helpers of the voxel cell material vote
package vcmv_pkg;

    localparam int NUM_SAMPLES   = 8;
    localparam int CODE_W        = 16;
    localparam int SCORE_W       = 4;
    localparam int ANCHOR_SAMPLE = 3;
    localparam int MAIN_BONUS    = 2;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    typedef logic [CODE_W-1:0]                   code_t;
    typedef logic [NUM_SAMPLES-1:0]              sample_mask_t;
    typedef logic [NUM_SAMPLES-1:0][CODE_W-1:0]  code_vec_t;
    typedef logic [SCORE_W-1:0]                  score_t;
    typedef logic [NUM_SAMPLES-1:0][SCORE_W-1:0] score_vec_t;

    // layer of each sample, bit i set when sample i lies in the upper layer
    localparam sample_mask_t LAYER_OF = 8'b1011_0001;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_AIR     = 2'd0,
        REG_IGNORE  = 2'd1,
        REG_UNKNOWN = 2'd2
    } reg_index_t;

    localparam code_t AIR_RESET     = 16'd126;
    localparam code_t IGNORE_RESET  = 16'd127;
    localparam code_t UNKNOWN_RESET = 16'd125;

    typedef struct packed {
        logic [63:0]  codes_low;
        logic [63:0]  codes_high;
        sample_mask_t exposed_mask;
        sample_mask_t opaque_mask;
        sample_mask_t cover_mask;
    } cell_beat_t;

    typedef struct packed {
        logic       found;
        logic [2:0] chosen_index;
    } vote_beat_t;

    // cell-wide decisions shared by every scoring lane
    typedef struct packed {
        logic sel_solid;
        logic any_opaque;
        logic mixed;
    } vote_ctx_t;

    function automatic score_t popcount8(input sample_mask_t bits);
        score_t acc;
        acc = '0;
        for (int k = 0; k < NUM_SAMPLES; k++) begin
            acc = acc + score_t'(bits[k]);
        end
        return acc;
    endfunction

endpackage

@@ hw/rtl/vcmv_lane.sv @@
// per-sample decode lane: validity, solidity and code match row
module vcmv_lane (
    input  vcmv_pkg::code_t        code,
    input  vcmv_pkg::code_vec_t    codes,
    input  vcmv_pkg::code_t        air_code,
    input  vcmv_pkg::code_t        ignore_code,
    input  vcmv_pkg::code_t        unknown_code,
    output logic                   valid,
    output logic                   solid,
    output vcmv_pkg::sample_mask_t eq_row
);
    import vcmv_pkg::*;

    always_comb
    begin
        valid = (code != ignore_code) && (code != unknown_code);
        solid = valid && (code != air_code);
        for (int j = 0; j < NUM_SAMPLES; j++) begin
            eq_row[j] = (codes[j] == code);
        end
    end

endmodule

@@ hw/rtl/vcmv_score.sv @@
// per-sample scoring lane: eligibility and vote count
module vcmv_score (
    input  vcmv_pkg::vote_ctx_t    ctx,
    input  logic                   valid,
    input  logic                   solid,
    input  logic                   cover_flag,
    input  logic                   is_main,
    input  logic                   in_count,
    input  vcmv_pkg::sample_mask_t eq_row,
    input  vcmv_pkg::sample_mask_t cnt_mask,
    output logic                   cand,
    output logic                   competes,
    output vcmv_pkg::score_t       score
);
    import vcmv_pkg::*;

    score_t n;

    always_comb
    begin
        cand     = valid && (solid == ctx.sel_solid)
                   && !(ctx.sel_solid && ctx.any_opaque && cover_flag);
        competes = cand && in_count;
        n        = popcount8(eq_row & cnt_mask);
        // main sample bonus in a partly air cell
        if (ctx.sel_solid && ctx.mixed && is_main && (n > score_t'(1))) begin
            score = n + score_t'(MAIN_BONUS);
        end
        else begin
            score = n;
        end
    end

endmodule

@@ hw/rtl/vcmv_merge.sv @@
// merge stage: highest score wins, main sample takes ties, else lowest index
module vcmv_merge (
    input  vcmv_pkg::sample_mask_t competes,
    input  vcmv_pkg::score_vec_t   scores,
    output vcmv_pkg::vote_beat_t   vote
);
    import vcmv_pkg::*;

    logic   found;
    logic [2:0] best_i;
    score_t best_n;

    always_comb
    begin
        found  = 1'b0;
        best_i = '0;
        best_n = '0;
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            if (competes[i] && (!found || (scores[i] > best_n)
                || ((scores[i] == best_n) && (i == ANCHOR_SAMPLE)))) begin
                found  = 1'b1;
                best_i = 3'(i);
                best_n = scores[i];
            end
        end
        vote.found        = found;
        vote.chosen_index = found ? best_i : 3'd0;
    end

endmodule

@@ hw/rtl/voxel_cell_material_vote.sv @@
// top level of the voxel cell material vote pipeline
//
// usage
//   cell channel: one beat carries the eight sample codes of a 2x2x2 cell and
//   the exposed, opaque and cover masks; a beat moves when cell_valid is high
//   and cell_stall is low
//   vote channel: one beat per cell with found and chosen_index, same rule on
//   vote_valid and vote_stall
//   throughput is one cell per cycle while vote_stall is low; eight decode
//   lanes compare every code pair in stage one, eight scoring lanes count votes
//   in stage two and the merge stage picks the winner into the output register
//   each stage holds its beat only while the stage after it is full and
//   stalled, so bubbles are squeezed out while the receiver stalls
//   cell_stall rises only when all three stages are full and vote_stall is high
//   reset empties the pipeline and loads air 126, ignore 127 and unknown 125
//   configuration (air, ignore, unknown codes at 0x0, 0x4, 0x8) is written by the user
//   through the apb port while the pipeline is empty, not enforced by the block; pready is always high
module voxel_cell_material_vote (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cell_valid,
    output logic                 cell_stall,
    input  vcmv_pkg::cell_beat_t cell_data,
    output logic                 vote_valid,
    input  logic                 vote_stall,
    output vcmv_pkg::vote_beat_t vote_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import vcmv_pkg::*;

    // configuration registers
    code_t air_reg;
    code_t ignore_reg;
    code_t unknown_reg;
    logic  cfg_write;
    reg_index_t cfg_idx;

    // stage one: decoded samples
    logic         s1_valid_reg;
    sample_mask_t s1_sval_reg;
    sample_mask_t s1_solid_reg;
    sample_mask_t s1_exp_reg;
    sample_mask_t s1_opaque_reg;
    sample_mask_t s1_cover_reg;
    sample_mask_t s1_eq_reg [NUM_SAMPLES];

    // stage two: lane scores
    logic         s2_valid_reg;
    sample_mask_t s2_comp_reg;
    score_vec_t   s2_score_reg;

    // output register
    logic       vote_valid_reg;
    vote_beat_t vote_data_reg;

    logic out_ready;
    logic s2_ready;
    logic s1_ready;

    code_vec_t    codes;
    sample_mask_t dec_valid;
    sample_mask_t dec_solid;
    sample_mask_t dec_eq [NUM_SAMPLES];

    vote_ctx_t    ctx;
    score_t       valid_n;
    score_t       solid_n;
    sample_mask_t cand;
    sample_mask_t competes;
    score_vec_t   scores;
    logic         top_any;
    logic         top_layer;
    sample_mask_t cnt_mask;
    vote_beat_t   merged;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_idx   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            air_reg     <= AIR_RESET;
            ignore_reg  <= IGNORE_RESET;
            unknown_reg <= UNKNOWN_RESET;
        end
        else if (cfg_write) begin
            unique case (cfg_idx)
                REG_AIR:     air_reg     <= pwdata[CODE_W-1:0];
                REG_IGNORE:  ignore_reg  <= pwdata[CODE_W-1:0];
                REG_UNKNOWN: unknown_reg <= pwdata[CODE_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_AIR:     prdata = {{(DATA_W-CODE_W){1'b0}}, air_reg};
            REG_IGNORE:  prdata = {{(DATA_W-CODE_W){1'b0}}, ignore_reg};
            REG_UNKNOWN: prdata = {{(DATA_W-CODE_W){1'b0}}, unknown_reg};
            default:     prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    // a stage may load when it is empty or its contents move on this cycle
    assign out_ready  = !vote_valid_reg || !vote_stall;
    assign s2_ready   = !s2_valid_reg || out_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign cell_stall = !s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            vote_valid_reg <= 1'b0;
        end
        else begin
            if (s1_ready) begin
                s1_valid_reg <= cell_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready) begin
                vote_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ---------------- stage one: decode lanes ----------------
    assign codes = code_vec_t'({cell_data.codes_high, cell_data.codes_low});

    for (genvar g = 0; g < NUM_SAMPLES; g++) begin : g_lane
        vcmv_lane u_lane (
            .code         (codes[g]),
            .codes        (codes),
            .air_code     (air_reg),
            .ignore_code  (ignore_reg),
            .unknown_code (unknown_reg),
            .valid        (dec_valid[g]),
            .solid        (dec_solid[g]),
            .eq_row       (dec_eq[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (cell_valid && s1_ready) begin
            s1_sval_reg   <= dec_valid;
            s1_solid_reg  <= dec_solid;
            s1_exp_reg    <= cell_data.exposed_mask;
            s1_opaque_reg <= cell_data.opaque_mask;
            s1_cover_reg  <= cell_data.cover_mask;
            s1_eq_reg     <= dec_eq;
        end
    end

    // ---------------- stage two: cell decisions and scoring lanes ----------------
    // a tie between solid and air samples makes the cell solid
    always_comb
    begin
        valid_n        = popcount8(s1_sval_reg);
        solid_n        = popcount8(s1_solid_reg);
        ctx.sel_solid  = {solid_n, 1'b0} >= {1'b0, valid_n};
        ctx.any_opaque = |(s1_solid_reg & s1_opaque_reg);
        ctx.mixed      = |(s1_sval_reg & ~s1_solid_reg);
    end

    // solid cell: only the exposed samples of the top exposed candidate layer, if any, count and compete
    always_comb
    begin
        top_any   = ctx.sel_solid && |(s1_exp_reg & cand);
        top_layer = |(s1_exp_reg & cand & LAYER_OF);
        if (top_any) begin
            cnt_mask = s1_exp_reg & (top_layer ? LAYER_OF : ~LAYER_OF);
        end
        else begin
            cnt_mask = '1;
        end
    end

    for (genvar g = 0; g < NUM_SAMPLES; g++) begin : g_score
        vcmv_score u_score (
            .ctx        (ctx),
            .valid      (s1_sval_reg[g]),
            .solid      (s1_solid_reg[g]),
            .cover_flag (s1_cover_reg[g]),
            .is_main    (g == ANCHOR_SAMPLE),
            .in_count   (cnt_mask[g]),
            .eq_row     (s1_eq_reg[g]),
            .cnt_mask   (cnt_mask),
            .cand       (cand[g]),
            .competes   (competes[g]),
            .score      (scores[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready) begin
            s2_comp_reg  <= competes;
            s2_score_reg <= scores;
        end
    end

    // ---------------- stage three: merge into the output register ----------------
    vcmv_merge u_merge (
        .competes (s2_comp_reg),
        .scores   (s2_score_reg),
        .vote     (merged)
    );

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && out_ready) begin
            vote_data_reg <= merged;
        end
    end

    assign vote_valid = vote_valid_reg;
    assign vote_data  = vote_data_reg;

    // ---------------- checks ----------------
    // input is held back only with the whole pipeline full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        cell_stall |-> (s1_valid_reg && s2_valid_reg && vote_valid_reg))
        else $error("cell stalled with room in the pipeline");

    // an accepted cell beat lands in stage one
    a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && !cell_stall) |=> s1_valid_reg)
        else $error("accepted cell beat lost at stage one");

    // a blocked stage two beat keeps its scores
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_ready) |=> (s2_valid_reg && $stable(s2_score_reg)
                                         && $stable(s2_comp_reg)))
        else $error("stage two beat changed while blocked");

    // no selection reports index zero
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vote_valid && !vote_data.found) |-> (vote_data.chosen_index == 3'd0))
        else $error("index set on a cell with no selection");

endmodule
